// File: sv/iel_pkg.sv
package iel_pkg;

  // Fixed field widths of the request and response items
  localparam int unsigned OpW     = 3;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // Default configuration
  localparam int unsigned DefDepth = 16;
  localparam int unsigned DefDataW = 32;

  // Request opcodes (6 and 7 are unused and report out of range)
  localparam logic [OpW-1:0] OP_PUSH   = 3'd0;
  localparam logic [OpW-1:0] OP_POP    = 3'd1;
  localparam logic [OpW-1:0] OP_INSERT = 3'd2;
  localparam logic [OpW-1:0] OP_ERASE  = 3'd3;
  localparam logic [OpW-1:0] OP_READ   = 3'd4;
  localparam logic [OpW-1:0] OP_CLEAR  = 3'd5;

  // Response status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd3;

  // Per-cycle command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_INS,
    CMD_ERS
  } cell_cmd_e;

endpackage

// File: sv/iel_req_if.sv
interface iel_req_if;
  logic                           valid;
  logic                           ready;
  logic [iel_pkg::OpW-1:0]        op;
  logic [iel_pkg::IndexW-1:0]     index;
  logic [iel_pkg::ValueW-1:0]     value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

// File: sv/iel_rsp_if.sv
interface iel_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [iel_pkg::StatusW-1:0]    status;
  logic [iel_pkg::ValueW-1:0]     read_value;
  logic [iel_pkg::CountW-1:0]     count;

  modport source (output valid, output status, output read_value, output count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input count,
                  output ready);
endinterface

// File: sv/iel_cell.sv
// One list slot. Takes the new word, its left or right neighbor, or holds.
module iel_cell #(
  parameter int unsigned DATA_W = iel_pkg::DefDataW,
  parameter int unsigned CNT_W  = 5,
  parameter int unsigned POS    = 0
) (
  input  logic                  clk_i,
  input  iel_pkg::cell_cmd_e    cmd_i,
  input  logic [CNT_W-1:0]      sel_i,
  input  logic [DATA_W-1:0]     val_i,
  input  logic [DATA_W-1:0]     left_i,
  input  logic [DATA_W-1:0]     right_i,
  output logic [DATA_W-1:0]     data_o,
  output logic [DATA_W-1:0]     rd_o
);

  localparam logic [CNT_W-1:0] MyPos = CNT_W'(POS);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i)
      iel_pkg::CMD_PUSH: begin
        if (MyPos == sel_i) data_d = val_i;
      end
      iel_pkg::CMD_INS: begin
        if (MyPos == sel_i) data_d = val_i;
        else if (MyPos > sel_i) data_d = left_i;
      end
      iel_pkg::CMD_ERS: begin
        if (MyPos >= sel_i) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the selected slot drives the read bus
  assign rd_o   = (MyPos == sel_i) ? data_q : '0;

endmodule

// File: sv/indexed_insert_erase_list.sv
// Ordered list of up to DEPTH words, held in a row of cells.
// Request channel req_i carries op, index and value; response channel rsp_o
// returns status, read_value and count, one response item per request item.
// Ops: push, pop, insert at index, erase at index, read at index, clear.
// A failing request (bad index, full, empty, unused opcode) changes nothing.
// The response item is registered and valid in the cycle after the request
// is taken. Throughput: one request per cycle while rsp_o does not stall.
// Insert and erase shift the cells from the index up, each by one place;
// the read goes through an OR bus across the row into the response register.
// Stall: the response register holds while rsp_o.ready is low; req_i.ready
// is high whenever that register is empty or being drained in this cycle.
// Reset: count goes to zero and the response register empties. Cell
// contents are not reset; slots at or above count are never read.
module indexed_insert_erase_list #(
  parameter int unsigned DEPTH  = iel_pkg::DefDepth,
  parameter int unsigned DATA_W = iel_pkg::DefDataW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  iel_req_if.sink      req_i,
  iel_rsp_if.source    rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // compare width: covers both the count and the raw index field
  localparam int unsigned CMP_W = (CNT_W > iel_pkg::IndexW) ? CNT_W : iel_pkg::IndexW;
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  // response register
  logic                           out_valid_q;
  logic [iel_pkg::StatusW-1:0]    status_q, status_d;
  logic [iel_pkg::ValueW-1:0]     rdval_q, rdval_d;
  logic [iel_pkg::CountW-1:0]     count_q;

  // cell row
  iel_pkg::cell_cmd_e  cmd;
  logic [CNT_W-1:0]    sel;
  logic [DATA_W-1:0]   new_val;
  logic [DATA_W-1:0]   cell_data [DEPTH];
  logic [DATA_W-1:0]   cell_rd   [DEPTH];
  logic [DATA_W-1:0]   rd_bus;

  logic [CMP_W-1:0] idx_w, cnt_w;
  logic             full, empty;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign idx_w   = CMP_W'(req_i.index);
  assign cnt_w   = CMP_W'(cnt_q);
  assign full    = (cnt_q == CntFull);
  assign empty   = (cnt_q == '0);
  assign new_val = DATA_W'(req_i.value);

  // decode: status, next count, read value and the row command
  always_comb begin
    cnt_d    = cnt_q;
    status_d = iel_pkg::ST_OK;
    cmd      = iel_pkg::CMD_NONE;
    sel      = CNT_W'(req_i.index);
    rdval_d  = '0;
    case (req_i.op)
      iel_pkg::OP_PUSH: begin
        sel = cnt_q;
        if (full) status_d = iel_pkg::ST_FULL;
        else begin
          cmd   = iel_pkg::CMD_PUSH;
          cnt_d = cnt_q + 1'b1;
        end
      end
      iel_pkg::OP_POP: begin
        if (empty) status_d = iel_pkg::ST_EMPTY;
        else cnt_d = cnt_q - 1'b1;
      end
      iel_pkg::OP_INSERT: begin
        if (idx_w > cnt_w) status_d = iel_pkg::ST_RANGE;
        else if (full) status_d = iel_pkg::ST_FULL;
        else begin
          cmd   = iel_pkg::CMD_INS;
          cnt_d = cnt_q + 1'b1;
        end
      end
      iel_pkg::OP_ERASE: begin
        if (empty) status_d = iel_pkg::ST_EMPTY;
        else if (idx_w >= cnt_w) status_d = iel_pkg::ST_RANGE;
        else begin
          cmd   = iel_pkg::CMD_ERS;
          cnt_d = cnt_q - 1'b1;
        end
      end
      iel_pkg::OP_READ: begin
        if (empty) status_d = iel_pkg::ST_EMPTY;
        else if (idx_w >= cnt_w) status_d = iel_pkg::ST_RANGE;
        else rdval_d = iel_pkg::ValueW'(rd_bus);
      end
      iel_pkg::OP_CLEAR: begin
        cnt_d = '0;
      end
      default: status_d = iel_pkg::ST_RANGE;
    endcase
    if (!accept) cmd = iel_pkg::CMD_NONE;
  end

  // row of cells; each shifts from its neighbor on insert or erase
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = cell_data[g];
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    iel_cell #(
      .DATA_W (DATA_W),
      .CNT_W  (CNT_W),
      .POS    (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .sel_i   (sel),
      .val_i   (new_val),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // read bus: at most one cell drives a nonzero word
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) cnt_q <= cnt_d;
      if (accept) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rdval_q  <= rdval_d;
      count_q  <= iel_pkg::CountW'(cnt_d);
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.read_value = rdval_q;
  assign rsp_o.count      = count_q;

  // count never passes capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("element count above capacity");

  // every accepted request yields a response in the next cycle
  a_rsp_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.valid)
    else $error("response missing after accepted request");

  // a full status is only reported while the list is full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == iel_pkg::ST_FULL) |-> full)
    else $error("full status with room left");

  // a failing request leaves the count unchanged
  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d != iel_pkg::ST_OK) |=> cnt_q == $past(cnt_q))
    else $error("count changed on failed request");

endmodule

// File: verif/iel_list_sb_pkg.sv
package iel_list_sb_pkg;

  // Spare opcodes: the block answers them with an out-of-range status
  localparam logic [iel_pkg::OpW-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [iel_pkg::OpW-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [iel_pkg::ValueW-1:0] DataMask =
    {iel_pkg::ValueW{1'b1}} >> (iel_pkg::ValueW - iel_pkg::DefDataW);

  typedef struct packed {
    logic [iel_pkg::StatusW-1:0] status;
    logic [iel_pkg::ValueW-1:0]  read_value;
    logic [iel_pkg::CountW-1:0]  count;
  } list_result_t;

  class list_scoreboard;
    logic [iel_pkg::ValueW-1:0] slots [iel_pkg::DefDepth];
    int unsigned                n_elems;
    list_result_t               expected_q [$];
    int unsigned                failures;

    function new();
      foreach (slots[i]) slots[i] = '0;
      n_elems  = 0;
      failures = 0;
    endfunction

    function int unsigned size();
      return n_elems;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its response
    function void note_request(logic [iel_pkg::OpW-1:0] op,
                               logic [iel_pkg::IndexW-1:0] index,
                               logic [iel_pkg::ValueW-1:0] value);
      list_result_t res;
      int unsigned  idx;
      res.status     = iel_pkg::ST_OK;
      res.read_value = '0;
      idx            = index;
      case (op)
        iel_pkg::OP_PUSH: begin
          if (n_elems >= iel_pkg::DefDepth) begin
            res.status = iel_pkg::ST_FULL;
          end else begin
            slots[n_elems] = value & DataMask;
            n_elems++;
          end
        end
        iel_pkg::OP_POP: begin
          if (n_elems == 0) res.status = iel_pkg::ST_EMPTY;
          else n_elems--;
        end
        iel_pkg::OP_INSERT: begin
          if (idx > n_elems) begin
            res.status = iel_pkg::ST_RANGE;
          end else if (n_elems >= iel_pkg::DefDepth) begin
            res.status = iel_pkg::ST_FULL;
          end else begin
            for (int i = n_elems; i > idx; i--) slots[i] = slots[i-1];
            slots[idx] = value & DataMask;
            n_elems++;
          end
        end
        iel_pkg::OP_ERASE: begin
          if (n_elems == 0) begin
            res.status = iel_pkg::ST_EMPTY;
          end else if (idx >= n_elems) begin
            res.status = iel_pkg::ST_RANGE;
          end else begin
            for (int i = idx; i + 1 < n_elems; i++) slots[i] = slots[i+1];
            n_elems--;
          end
        end
        iel_pkg::OP_READ: begin
          if (n_elems == 0) res.status = iel_pkg::ST_EMPTY;
          else if (idx >= n_elems) res.status = iel_pkg::ST_RANGE;
          else res.read_value = slots[idx];
        end
        iel_pkg::OP_CLEAR: n_elems = 0;
        default: res.status = iel_pkg::ST_RANGE;
      endcase
      res.count = iel_pkg::CountW'(n_elems);
      expected_q = {expected_q, res};
    endfunction

    function void check_response(logic [iel_pkg::StatusW-1:0] status,
                                 logic [iel_pkg::ValueW-1:0] read_value,
                                 logic [iel_pkg::CountW-1:0] count);
      list_result_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected response item: status %0d read_value %h count %0d",
               status, read_value, count);
        failures++;
        return;
      end
      exp = expected_q.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        failures++;
      end
      if (read_value !== exp.read_value) begin
        $error("read_value: expected %h, got %h", exp.read_value, read_value);
        failures++;
      end
      if (count !== exp.count) begin
        $error("count: expected %0d, got %0d", exp.count, count);
        failures++;
      end
    endfunction
  endclass

endpackage

// File: verif/indexed_insert_erase_list_tb.sv
module indexed_insert_erase_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iel_pkg::*;
  import iel_list_sb_pkg::*;

  localparam int unsigned NumRandom   = 1200;
  localparam int unsigned MaxIdle     = 16;
  localparam int unsigned HoldAfter   = 300;  // response count at which the long hold starts
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned PauseAt     = 600;  // random item before which the sender drains
  localparam int unsigned DrainCycles = 10;

  // Random items lean toward growing, shrinking or churning the list
  typedef enum int unsigned {
    TREND_GROW,
    TREND_SHRINK,
    TREND_MIXED
  } trend_e;

  // Weights per op slot: push, pop, insert, erase, read, clear, spare
  typedef int unsigned op_weights_t [7];
  localparam logic [OpW-1:0] OpBySlot [6] =
    '{OP_PUSH, OP_POP, OP_INSERT, OP_ERASE, OP_READ, OP_CLEAR};

  logic clk_i;
  logic rst_ni;

  iel_req_if req_if ();
  iel_rsp_if rsp_if ();

  indexed_insert_erase_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  list_scoreboard sb = new();

  // Idle modes: 0 never idle, 1 uniform 0..MaxIdle, 2 mostly back to back
  int unsigned send_idle_mode;
  int unsigned recv_idle_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_cycles(int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, MaxIdle);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MaxIdle) : 0;
    endcase
  endfunction

  // Pick one request; indexes mostly land inside the list so that inserts and
  // erases really move elements, with boundary and wild indexes mixed in.
  function automatic void draw_request(input trend_e trend,
                                       output logic [OpW-1:0] op,
                                       output logic [IndexW-1:0] index,
                                       output logic [ValueW-1:0] value);
    op_weights_t w;
    int unsigned n;
    int unsigned roll;
    int unsigned acc;
    int unsigned slot;
    int unsigned hi;
    int unsigned pick;
    n = sb.size();
    case (trend)
      TREND_GROW:   w = '{30, 7, 30, 8, 20, 1, 4};
      TREND_SHRINK: w = '{8, 30, 8, 30, 20, 1, 3};
      default:      w = '{18, 18, 18, 18, 20, 3, 5};
    endcase
    roll = $urandom_range(0, 99);
    slot = 0;
    acc  = w[0];
    while (roll >= acc) begin
      slot++;
      acc += w[slot];
    end
    if (slot == 6) op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    else op = OpBySlot[slot];

    case (op)
      OP_INSERT:         hi = n;
      OP_ERASE, OP_READ: hi = (n == 0) ? 0 : n - 1;
      default:           hi = DefDepth;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 8) index = IndexW'($urandom_range(0, hi));
    else if (pick == 8) index = IndexW'(n + $urandom_range(0, 1));  // just at / past the end
    else index = IndexW'($urandom());

    if ($urandom_range(0, 15) == 0) value = $urandom_range(0, 1) ? '1 : '0;
    else value = $urandom();
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [OpW-1:0] op, input logic [IndexW-1:0] index,
                              input logic [ValueW-1:0] value);
    int unsigned gap;
    gap = idle_cycles(send_idle_mode);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.index <= index;
    req_if.value <= value;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, index, value);
    @(negedge clk_i);
  endtask

  // Request side: reset, directed corner cases, then biased random traffic
  initial begin
    trend_e            trend;
    logic [OpW-1:0]    op;
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;

    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.op      = OP_PUSH;
    req_if.index   = '0;
    req_if.value   = '0;
    send_idle_mode = 1;
    trend          = TREND_GROW;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: pop, erase and read must fail; also bad insert, spare ops, clear
    send_request(OP_POP, 0, 32'h0);
    send_request(OP_ERASE, 0, 32'h0);
    send_request(OP_READ, 0, 32'h0);
    send_request(OP_INSERT, 1, 32'h1234_5678);   // index past the end
    send_request(OP_SPARE_LO, 0, 32'h0);
    send_request(OP_SPARE_HI, '1, '1);
    send_request(OP_CLEAR, 0, 32'h0);            // clear with nothing to clear
    // small list: front insert, append through insert, extreme words
    send_request(OP_PUSH, 0, 32'h0000_0000);
    send_request(OP_INSERT, 0, 32'hffff_ffff);
    send_request(OP_INSERT, 2, 32'ha5a5_5a5a);   // index == count appends
    send_request(OP_READ, 1, 32'h0);
    send_request(OP_READ, '1, 32'h0);            // widest index
    send_request(OP_ERASE, 3, 32'h0);            // index == count is out of range
    send_request(OP_ERASE, 0, 32'h0);
    send_request(OP_READ, 0, 32'h0);
    send_request(OP_POP, 0, 32'h0);
    send_request(OP_CLEAR, 0, 32'h0);            // clear a non-empty list

    // Random part starts growing so full-list cases show up early
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 40 == 0 && n != 0) trend = trend_e'($urandom_range(0, 2));
      if (n % 64 == 0) send_idle_mode = $urandom_range(0, 2);
      if (n == PauseAt) begin
        // let the pipe run dry before carrying on
        req_if.valid <= 1'b0;
        do @(negedge clk_i); while (sb.pending() != 0);
      end
      draw_request(trend, op, index, value);
      send_request(op, index, value);
    end
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Response side: random back-pressure plus one long hold so that the
  // response register fills and the request channel stalls behind it.
  initial begin
    int unsigned stall;
    int unsigned taken;
    rsp_if.ready   = 1'b0;
    recv_idle_mode = 1;
    taken          = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 64 == 0) recv_idle_mode = $urandom_range(0, 2);
      stall = (taken == HoldAfter) ? HoldCycles : idle_cycles(recv_idle_mode);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      sb.check_response(rsp_if.status, rsp_if.read_value, rsp_if.count);
      taken++;
      @(negedge clk_i);
    end
  end

  // Watchdog: roughly seven times the slowest legal run
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
sv/iel_pkg.sv
sv/iel_req_if.sv
sv/iel_rsp_if.sv
sv/iel_cell.sv
sv/indexed_insert_erase_list.sv
verif/iel_list_sb_pkg.sv
verif/indexed_insert_erase_list_tb.sv
